// ----- hdl/sab_pkg.sv -----
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the sorted array binary search core.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int VALUE_W     = 32;
    localparam int ENTRY_IDX_W = 10;
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 10;
    localparam int MODE_W      = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_ANY   = 2'd1,
        MODE_FIRST = 2'd2,
        MODE_LAST  = 2'd3
    } t_mode;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic start;
        logic probe;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic range_empty;
        logic hit;
        logic mode_any;
        logic out_full;
    } t_dp_stat;

endpackage

// ----- hdl/sab_ram.sv -----
// ----------------------------------------------------------------------------
// sab_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sab_ctrl.sv -----
// ----------------------------------------------------------------------------
// sab_ctrl
// Search sequencer: accepts requests, steps probes, hands off the result.
// ----------------------------------------------------------------------------
module sab_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [sab_pkg::MODE_W-1:0]    i_in_mode,
    input  sab_pkg::t_dp_stat             i_stat,
    output logic                          o_in_ready,
    output sab_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_is_load;

    assign w_is_load  = (i_in_mode == sab_pkg::MODE_LOAD);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (w_is_load) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (i_stat.range_empty) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                o_cmd.step = 1'b1;
                // stop at the first match for an any-match request
                if (i_stat.hit && i_stat.mode_any) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!i_stat.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_compare_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPARE) |-> ($past(r_state) == ST_CHECK))
        else $error("compare step without a preceding read");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_stat.out_full)
        else $error("result loaded over an untaken result");

    a_probe_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe |-> !i_stat.range_empty)
        else $error("probe issued on an empty range");

endmodule

// ----- hdl/sab_dp.sv -----
// ----------------------------------------------------------------------------
// sab_dp
// Datapath: entry store, range bounds, probe compare and result register.
// ----------------------------------------------------------------------------
module sab_dp #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sab_pkg::t_dp_cmd                   i_cmd,
    input  logic [sab_pkg::MODE_W-1:0]         i_mode,
    input  logic [sab_pkg::ENTRY_IDX_W-1:0]    i_entry_index,
    input  logic signed [sab_pkg::VALUE_W-1:0] i_item_value,
    input  logic [sab_pkg::COUNT_W-1:0]        i_entry_count,
    input  logic                               i_out_ready,
    output sab_pkg::t_dp_stat                  o_stat,
    output logic                               o_out_valid,
    output logic                               o_found,
    output logic [sab_pkg::POS_W-1:0]          o_position
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [31:0] MAX_U = 32'(MAX_ENTRIES);

    logic [CW-1:0]                      r_lo;
    logic [CW-1:0]                      r_hi_ex;
    logic [AW-1:0]                      r_mid;
    logic [AW-1:0]                      r_hit;
    logic                               r_found;
    logic signed [sab_pkg::VALUE_W-1:0] r_target;
    sab_pkg::t_mode                     r_mode;
    logic                               r_out_valid;
    logic                               r_out_found;
    logic [sab_pkg::POS_W-1:0]          r_out_pos;

    logic [31:0]                 w_count_ext;
    logic [CW-1:0]               w_limit;
    logic                        w_idx_ok;
    logic                        w_we;
    logic [CW:0]                 w_sum;
    logic [AW-1:0]               w_mid;
    logic [CW-1:0]               w_mid_inc;
    logic [sab_pkg::VALUE_W-1:0] w_rdata;
    logic                        w_eq;
    logic                        w_lt;

    // saturate the count to the store depth
    assign w_count_ext = {{(32 - sab_pkg::COUNT_W){1'b0}}, i_entry_count};
    assign w_limit     = (w_count_ext > MAX_U) ? CW'(MAX_ENTRIES) : CW'(w_count_ext);

    // drop loads beyond the store
    assign w_idx_ok = ({{(32 - sab_pkg::ENTRY_IDX_W){1'b0}}, i_entry_index} < MAX_U);
    assign w_we     = i_cmd.load && w_idx_ok;

    // floor((lo + hi) / 2) with hi = hi_ex - 1; only used when lo < hi_ex
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi_ex} - {{CW{1'b0}}, 1'b1};
    assign w_mid     = w_sum[AW:1];
    assign w_mid_inc = CW'(r_mid) + CW'(1);

    sab_ram #(
        .WIDTH (sab_pkg::VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_item_value),
        .i_re    (i_cmd.probe),
        .i_raddr (w_mid),
        .o_rdata (w_rdata)
    );

    assign w_eq = ($signed(w_rdata) == r_target);
    assign w_lt = ($signed(w_rdata) < r_target);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lo     <= '0;
            r_hi_ex  <= w_limit;
            r_target <= i_item_value;
            r_mode   <= sab_pkg::t_mode'(i_mode);
            r_found  <= 1'b0;
            r_hit    <= '0;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.step) begin
            if (w_eq) begin
                r_found <= 1'b1;
                r_hit   <= r_mid;
                // narrow left for first occurrence, right otherwise
                if (r_mode == sab_pkg::MODE_FIRST) begin
                    r_hi_ex <= CW'(r_mid);
                end else begin
                    r_lo <= w_mid_inc;
                end
            end else if (w_lt) begin
                r_lo <= w_mid_inc;
            end else begin
                r_hi_ex <= CW'(r_mid);
            end
        end
        if (i_cmd.finish) begin
            r_out_found <= r_found;
            r_out_pos   <= sab_pkg::POS_W'(r_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.range_empty = !(r_lo < r_hi_ex);
    assign o_stat.hit         = w_eq;
    assign o_stat.mode_any    = (r_mode == sab_pkg::MODE_ANY);
    assign o_stat.out_full    = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;

    a_range_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> ((r_hi_ex - r_lo) < $past(r_hi_ex - r_lo)))
        else $error("search range did not shrink after a probe");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished search left no result");

    a_hit_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && w_eq) |=> (r_found && (CW'(r_hit) < w_limit)))
        else $error("match recorded outside the searched range");

endmodule

// ----- hdl/sorted_array_binary_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_array_binary_search_core - binary search over a loaded sorted store
// Load requests write the store in the idle state and give no result. A
// search makes P probes, P <= floor(log2(count)) + 1 (11 for 1024 entries),
// each a registered store read and then a compare. A new request is taken
// only in the idle state, after the result has gone to the output register.
// Synchronous active-low reset clears the count and control; store undefined.
// ----------------------------------------------------------------------------
module sorted_array_binary_search_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: entry_count
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sab_pkg::COUNT_W-1:0]       i_cfg_data,
    // requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sab_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [9:0] entry_index, [41:10] item_value
    input  logic [sab_pkg::MODE_W-1:0]        s_axis_tuser,  // [1:0] mode
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sab_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [9:0] position
    output logic [0:0]                        m_axis_tuser   // [0] found
);

    logic [sab_pkg::COUNT_W-1:0] r_entry_count;
    sab_pkg::t_dp_cmd            w_cmd;
    sab_pkg::t_dp_stat           w_stat;
    logic                        w_found;
    logic [sab_pkg::POS_W-1:0]   w_position;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    sab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    sab_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_mode        (s_axis_tuser),
        .i_entry_index (s_axis_tdata[sab_pkg::ENTRY_IDX_W-1:0]),
        .i_item_value  (s_axis_tdata[sab_pkg::ENTRY_IDX_W +: sab_pkg::VALUE_W]),
        .i_entry_count (r_entry_count),
        .i_out_ready   (m_axis_tready),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_found       (w_found),
        .o_position    (w_position)
    );

    assign m_axis_tdata = {{(sab_pkg::OUT_DATA_W - sab_pkg::POS_W){1'b0}}, w_position};
    assign m_axis_tuser = w_found;

endmodule
